[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deque checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define DQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication
`define DQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

[rtl/core/dq_pkg.sv]
// ----------------------------------------------------------------------------
// Deque package
// Request kinds, status codes, cell operations and controller states.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Request kinds
    typedef enum logic [2:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_READ       = 3'd4,
        KIND_WRITE      = 3'd5,
        KIND_INSERT     = 3'd6,
        KIND_ERASE      = 3'd7
    } t_kind;

    // Result status
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Operation broadcast along the cell row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_ERASE  = 2'd3
    } t_cell_op;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LOOKUP = 2'd1,
        S_EXEC   = 2'd2
    } t_state;

endpackage

[rtl/core/dq_if.sv]
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready request and response channels of the deque engine.
// ----------------------------------------------------------------------------

// Request channel: kind, logical position and data word
interface dq_req_if #(
    parameter int POS_W      = 6,
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            kind;
    logic [POS_W-1:0]      position;
    logic [DATA_WIDTH-1:0] data_value;

    modport source (output valid, kind, position, data_value, input ready);
    modport sink   (input valid, kind, position, data_value, output ready);
endinterface

// Response channel: returned word, element count and status
interface dq_rsp_if #(
    parameter int CNT_W      = 7,
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] read_value;
    logic [CNT_W-1:0]      element_count;
    logic [1:0]            status;

    modport source (output valid, read_value, element_count, status, input ready);
    modport sink   (input valid, read_value, element_count, status, output ready);
endinterface

[rtl/core/dq_cell.sv]
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds the element at one logical index; loads, holds or takes a neighbor.
// ----------------------------------------------------------------------------
module dq_cell
    import dq_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 6,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [POS_W-1:0]      i_idx,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Cell action from the broadcast operation and target index
    always_comb begin
        n_data = r_data;
        case (i_op)
            CELL_WRITE: begin
                if (MY_IDX == i_idx) n_data = i_data;
            end
            CELL_INSERT: begin
                // cells above the slot move up one, the slot takes the new word
                if (MY_IDX > i_idx)       n_data = i_left;
                else if (MY_IDX == i_idx) n_data = i_data;
            end
            CELL_ERASE: begin
                // the slot and all above it take the word from above
                if (MY_IDX >= i_idx) n_data = i_right;
            end
            default: ;
        endcase
    end

    // Payload register, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[rtl/core/dq_read_tree.sv]
// ----------------------------------------------------------------------------
// Deque read tree
// Two-level select of one cell: registered group stage, then final select.
// ----------------------------------------------------------------------------
module dq_read_tree
    import dq_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 64,
    parameter int POS_W      = 6
) (
    input  logic                  i_clk,
    input  logic [DATA_WIDTH-1:0] i_cells [DEPTH],
    input  logic [POS_W-1:0]      i_idx,
    output logic [DATA_WIDTH-1:0] o_value
);

    localparam int LOW_W  = (POS_W < 3) ? POS_W : 3;
    localparam int HIGH_W = POS_W - LOW_W;
    localparam int GRP    = 1 << LOW_W;
    localparam int NSEL   = 1 << HIGH_W;

    logic [DATA_WIDTH-1:0] w_pad [NSEL][GRP];
    logic [DATA_WIDTH-1:0] r_grp [NSEL];
    logic [LOW_W-1:0]      w_low;

    assign w_low = i_idx[LOW_W-1:0];

    // Pad the cell row out to whole groups
    for (genvar g = 0; g < NSEL; g++) begin : g_grp
        for (genvar k = 0; k < GRP; k++) begin : g_lane
            if (g * GRP + k < DEPTH) begin : g_real
                assign w_pad[g][k] = i_cells[g * GRP + k];
            end else begin : g_fill
                assign w_pad[g][k] = '0;
            end
        end
    end

    // First level: pick the lane within every group
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NSEL; g++) begin
            r_grp[g] <= w_pad[g][w_low];
        end
    end

    // Second level: pick the group
    if (HIGH_W > 0) begin : g_sel
        assign o_value = r_grp[i_idx[POS_W-1:LOW_W]];
    end else begin : g_one
        assign o_value = r_grp[0];
    end

endmodule

[rtl/core/double_ended_queue_engine.sv]
// A request transfer passes through the LOOKUP and EXEC states before the response register
// is loaded. Requests are handled one at a time (accept, lookup, apply): a new one is
//   accepted only in IDLE; a held response stalls the apply step of the next request.
// The lookup cycle is the registered group stage of the read tree.
// Reset: synchronous, active low; clears count and control, cell contents
//   stay undefined until written (no clearing pass).
// ----------------------------------------------------------------------------
// Double-ended queue engine
// Bounded deque held in a row of cells indexed by logical position.
// ----------------------------------------------------------------------------
module double_ended_queue_engine
    import dq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dq_req_if.sink     i_req,
    dq_rsp_if.source   o_rsp
);

    localparam int POS_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // Controller state
    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;

    // Request captured at transfer
    t_status               r_status;
    t_cell_op              r_op;
    logic [POS_W-1:0]      r_idx;
    logic [DATA_WIDTH-1:0] r_data;
    logic [CNT_W-1:0]      r_cnt_next;
    logic                  r_returns;

    // Output register
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic [CNT_W-1:0]      r_out_count;
    t_status               r_out_status;

    // Decode of the incoming request
    t_status               w_status;
    t_cell_op              w_op;
    logic [POS_W-1:0]      w_idx;
    logic [CNT_W-1:0]      w_cnt_next;
    logic                  w_returns;
    logic [CNT_W-1:0]      w_pos_ext;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_in_xfer;
    logic                  w_out_free;
    logic                  w_apply;
    t_cell_op              w_bcast_op;

    logic [DATA_WIDTH-1:0] w_cell [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd_value;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_xfer   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_apply     = (r_state == S_EXEC) && w_out_free;
    assign w_pos_ext   = CNT_W'(i_req.position);
    assign w_full      = (r_count == FULL_CNT);
    assign w_empty     = (r_count == '0);

    // Request decode: status, cell operation, lookup index, new count
    always_comb begin
        w_status   = ST_OK;
        w_op       = CELL_HOLD;
        w_idx      = i_req.position;
        w_cnt_next = r_count;
        w_returns  = 1'b0;
        case (t_kind'(i_req.kind))
            KIND_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op       = CELL_INSERT;
                    w_idx      = r_count[POS_W-1:0];
                    w_cnt_next = r_count + 1'b1;
                end
            end
            KIND_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op       = CELL_INSERT;
                    w_idx      = '0;
                    w_cnt_next = r_count + 1'b1;
                end
            end
            KIND_POP_BACK: begin
                w_idx = POS_W'(r_count - 1'b1);
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_returns  = 1'b1;
                    w_cnt_next = r_count - 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                w_idx = '0;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op       = CELL_ERASE;
                    w_returns  = 1'b1;
                    w_cnt_next = r_count - 1'b1;
                end
            end
            KIND_READ: begin
                if (w_pos_ext >= r_count) w_status  = ST_RANGE;
                else                      w_returns = 1'b1;
            end
            KIND_WRITE: begin
                if (w_pos_ext >= r_count) w_status = ST_RANGE;
                else                      w_op     = CELL_WRITE;
            end
            KIND_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_ext > r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op       = CELL_INSERT;
                    w_cnt_next = r_count + 1'b1;
                end
            end
            KIND_ERASE: begin
                if (w_pos_ext >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op       = CELL_ERASE;
                    w_returns  = 1'b1;
                    w_cnt_next = r_count - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Capture the decoded request
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_status   <= w_status;
            r_op       <= w_op;
            r_idx      <= w_idx;
            r_data     <= i_req.data_value;
            r_cnt_next <= w_cnt_next;
            r_returns  <= w_returns;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_xfer) n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_EXEC;
            S_EXEC:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)     r_count <= '0;
        else if (w_apply) r_count <= r_cnt_next;
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out_value  <= r_returns ? w_rd_value : '0;
            r_out_count  <= r_cnt_next;
            r_out_status <= r_status;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_value    = r_out_value;
    assign o_rsp.element_count = r_out_count;
    assign o_rsp.status        = r_out_status;

    // Cell row: operation is broadcast only on the apply cycle
    assign w_bcast_op = w_apply ? r_op : CELL_HOLD;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = r_data;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        dq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .POS_W      (POS_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_bcast_op),
            .i_idx   (r_idx),
            .i_data  (r_data),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    // Lookup of the returned element before the row changes
    dq_read_tree #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH),
        .POS_W      (POS_W)
    ) u_read_tree (
        .i_clk   (i_clk),
        .i_cells (w_cell),
        .i_idx   (r_idx),
        .o_value (w_rd_value)
    );

endmodule

[rtl/core/dq_checker.sv]
// ----------------------------------------------------------------------------
// Deque port checker
// Watches the response port for count, status and hold rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_checker
    import dq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [DATA_WIDTH-1:0]         i_rsp_value,
    input logic [$clog2(DEPTH + 1)-1:0]  i_rsp_count,
    input logic [1:0]                    i_rsp_status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // Count never exceeds the capacity
    `DQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, i_rsp_valid, i_rsp_count <= FULL_CNT)

    // A full refusal reports a full store
    `DQ_ASSERT_IMP(a_full_count, i_clk, i_rst_n,
                   i_rsp_valid && (i_rsp_status == ST_FULL), i_rsp_count == FULL_CNT)

    // An empty refusal reports an empty store
    `DQ_ASSERT_IMP(a_empty_count, i_clk, i_rst_n,
                   i_rsp_valid && (i_rsp_status == ST_EMPTY), i_rsp_count == '0)

    // Refused requests return no data
    `DQ_ASSERT_IMP(a_refused_zero, i_clk, i_rst_n,
                   i_rsp_valid && (i_rsp_status != ST_OK), i_rsp_value == '0)

    // A stalled response holds
    `DQ_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready,
                   i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_count)
                   && $stable(i_rsp_status))

endmodule

bind double_ended_queue_engine dq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_value  (o_rsp.read_value),
    .i_rsp_count  (o_rsp.element_count),
    .i_rsp_status (o_rsp.status)
);

[dv/double_ended_queue_engine_tb.sv]
// ----------------------------------------------------------------------------
// Deque engine testbench
// Sends a directed set of requests and then random grow, shrink and mixed
// runs through the request channel. Each transfer is applied to a local
// model of the deque, and every response is checked against that
// prediction, field by field and in order. Both sides idle at random, and
// the receiver holds off for long stretches so that the engine backs up.
// ----------------------------------------------------------------------------
module double_ended_queue_engine_tb;
    import dq_pkg::*;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 7;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {
        RUN_GROW,
        RUN_SHRINK,
        RUN_MIX
    } t_run;

    typedef struct {
        t_kind                 kind;
        logic [POS_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] data;
    } t_request;

    typedef struct {
        logic [DATA_WIDTH-1:0] value;
        logic [CNT_W-1:0]      count;
        t_status               status;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dq_req_if #(.POS_W(POS_W), .DATA_WIDTH(DATA_WIDTH)) req_ch ();
    dq_rsp_if #(.CNT_W(CNT_W), .DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

    double_ended_queue_engine #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Requests waiting to be sent and responses still owed
    t_request pending_q[$];
    t_outcome owed_q[$];

    // Local deque model
    logic [DATA_WIDTH-1:0] slots [DEPTH];
    logic [POS_W-1:0]      head;
    logic [CNT_W-1:0]      held;

    int n_sent     = 0;
    int n_received = 0;
    int n_total    = 0;
    int fail_count = 0;
    int tx_idle_pct = 14;
    int rx_idle_pct = 53;
    int gen_count   = 0;

    int hold_left = 0;
    int hold_idx  = 0;
    int hold_marks [2] = '{300, 1100};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Physical slot of a logical index
    function automatic logic [POS_W-1:0] slot_at(int logical);
        return POS_W'(int'(head) + logical);
    endfunction

    // Apply one request to the local deque and return its response
    function automatic t_outcome apply_request(t_request r);
        t_outcome o;
        int i;
        o.value  = '0;
        o.status = ST_OK;
        case (r.kind)
            KIND_PUSH_BACK: begin
                if (held == DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    slots[slot_at(held)] = r.data;
                    held = held + 1'b1;
                end
            end
            KIND_PUSH_FRONT: begin
                if (held == DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    head = head - 1'b1;
                    slots[head] = r.data;
                    held = held + 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (held == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.value = slots[slot_at(held - 1)];
                    held = held - 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                if (held == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.value = slots[head];
                    head = head + 1'b1;
                    held = held - 1'b1;
                end
            end
            KIND_READ: begin
                if (r.pos >= held) o.status = ST_RANGE;
                else o.value = slots[slot_at(r.pos)];
            end
            KIND_WRITE: begin
                if (r.pos >= held) o.status = ST_RANGE;
                else slots[slot_at(r.pos)] = r.data;
            end
            KIND_INSERT: begin
                // full check wins over the index check
                if (held == DEPTH) begin
                    o.status = ST_FULL;
                end else if (r.pos > held) begin
                    o.status = ST_RANGE;
                end else begin
                    for (i = held; i > r.pos; i--)
                        slots[slot_at(i)] = slots[slot_at(i - 1)];
                    slots[slot_at(r.pos)] = r.data;
                    held = held + 1'b1;
                end
            end
            default: begin
                if (r.pos >= held) begin
                    o.status = ST_RANGE;
                end else begin
                    o.value = slots[slot_at(r.pos)];
                    for (i = r.pos; i + 1 < held; i++)
                        slots[slot_at(i)] = slots[slot_at(i + 1)];
                    held = held - 1'b1;
                end
            end
        endcase
        o.count = held;
        return o;
    endfunction

    // Element count after a request, used while building the stimulus
    function automatic int count_after(t_request r, int c);
        case (r.kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: return (c < DEPTH) ? c + 1 : c;
            KIND_INSERT:    return (c < DEPTH && r.pos <= c) ? c + 1 : c;
            KIND_POP_BACK, KIND_POP_FRONT:   return (c > 0) ? c - 1 : c;
            KIND_ERASE:     return (r.pos < c) ? c - 1 : c;
            default:        return c;
        endcase
    endfunction

    task automatic add_item(t_kind kind, int pos, logic [DATA_WIDTH-1:0] data);
        t_request r;
        r.kind = kind;
        r.pos  = POS_W'(pos);
        r.data = data;
        pending_q.insert(pending_q.size(), r);
        gen_count = count_after(r, gen_count);
    endtask

    // Random request biased by the kind of run
    function automatic t_request random_request(t_run run, int c);
        t_request r;
        int pick;
        int span;
        pick = $urandom_range(99);
        case (run)
            RUN_GROW: begin
                if (pick < 45)      r.kind = KIND_PUSH_BACK;
                else if (pick < 65) r.kind = KIND_PUSH_FRONT;
                else if (pick < 85) r.kind = KIND_INSERT;
                else                r.kind = t_kind'($urandom_range(7));
            end
            RUN_SHRINK: begin
                if (pick < 28)      r.kind = KIND_POP_BACK;
                else if (pick < 56) r.kind = KIND_POP_FRONT;
                else if (pick < 85) r.kind = KIND_ERASE;
                else                r.kind = t_kind'($urandom_range(7));
            end
            default: r.kind = t_kind'($urandom_range(7));
        endcase
        // mostly a valid index, sometimes anything
        span = (r.kind == KIND_INSERT) ? c + 1 : c;
        if (span > DEPTH) span = DEPTH;
        if (span > 0 && $urandom_range(99) < 85) r.pos = POS_W'($urandom_range(span - 1));
        else r.pos = POS_W'($urandom_range(DEPTH - 1));
        case ($urandom_range(9))
            0:       r.data = '0;
            1:       r.data = '1;
            default: r.data = $urandom;
        endcase
        return r;
    endfunction

    // Request driver: model update happens at the transfer
    always @(posedge i_clk) begin
        t_request cur;
        if (!i_rst_n) begin
            req_ch.valid      <= 1'b0;
            req_ch.kind       <= KIND_PUSH_BACK;
            req_ch.position   <= '0;
            req_ch.data_value <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                cur = pending_q[0];
                pending_q.delete(0);
                owed_q.insert(owed_q.size(), apply_request(cur));
                n_sent <= n_sent + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    req_ch.valid      <= 1'b1;
                    req_ch.kind       <= pending_q[0].kind;
                    req_ch.position   <= pending_q[0].pos;
                    req_ch.data_value <= pending_q[0].data;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response ready, with long hold-offs at set points
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_idx < 2 && n_received >= hold_marks[hold_idx]) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_idx     <= hold_idx + 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Response monitor
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_received <= n_received + 1;
            if (owed_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR: response with none owed: value=%h count=%0d status=%0d",
                             rsp_ch.read_value, rsp_ch.element_count, rsp_ch.status);
            end else begin
                want = owed_q[0];
                owed_q.delete(0);
                if (rsp_ch.read_value !== want.value ||
                    rsp_ch.element_count !== want.count ||
                    rsp_ch.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("ERROR: response %0d: expected value %h count %0d status %0d",
                                 n_received, want.value, want.count, want.status);
                        $display("       actual value %h count %0d status %0d",
                                 rsp_ch.read_value, rsp_ch.element_count, rsp_ch.status);
                    end
                end
            end
        end
    end

    // Stimulus, idle phases and end of run
    initial begin
        t_run run;
        int n_random;
        int extra;
        int run_len;

        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_PUSH_BACK;
        req_ch.position   = '0;
        req_ch.data_value = '0;
        rsp_ch.ready      = 1'b0;
        head = '0;
        held = '0;
        foreach (slots[i]) slots[i] = '0;

        // Directed: refusals on empty, edges of the data word, every kind,
        // pointer wrap at the front and popping the last element
        add_item(KIND_POP_BACK,   0, '0);
        add_item(KIND_POP_FRONT,  0, '0);
        add_item(KIND_READ,       0, '0);
        add_item(KIND_WRITE,      0, 32'h1);
        add_item(KIND_ERASE,      0, '0);
        add_item(KIND_INSERT,     1, 32'h2);
        add_item(KIND_READ,      63, '0);
        add_item(KIND_INSERT,     0, 32'hFFFF_FFFF);
        add_item(KIND_PUSH_BACK,  0, 32'h0);
        add_item(KIND_PUSH_FRONT, 0, 32'hA5A5_A5A5);
        add_item(KIND_READ,       2, '0);
        add_item(KIND_READ,       3, '0);
        add_item(KIND_WRITE,      1, 32'h5A5A_5A5A);
        add_item(KIND_INSERT,     3, 32'h8000_0001);
        add_item(KIND_INSERT,     1, 32'h7FFF_FFFE);
        add_item(KIND_INSERT,     6, 32'h3);
        add_item(KIND_ERASE,      4, '0);
        add_item(KIND_ERASE,      0, '0);
        add_item(KIND_READ,       0, '0);
        add_item(KIND_POP_FRONT,  0, '0);
        add_item(KIND_POP_BACK,  63, '1);
        add_item(KIND_POP_FRONT,  0, '0);
        add_item(KIND_PUSH_FRONT, 0, 32'h1234_5678);
        add_item(KIND_POP_BACK,   0, '0);

        // Random runs: grow to full, shrink to empty, or mixed traffic
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            run = t_run'($urandom_range(2));
            if (run == RUN_MIX) begin
                run_len = $urandom_range(20, 120);
                repeat (run_len) begin
                    pending_q.insert(pending_q.size(), random_request(run, gen_count));
                    gen_count = count_after(pending_q[$], gen_count);
                    n_random++;
                end
            end else begin
                extra = $urandom_range(2, 6);
                while (extra > 0) begin
                    pending_q.insert(pending_q.size(), random_request(run, gen_count));
                    gen_count = count_after(pending_q[$], gen_count);
                    n_random++;
                    if ((run == RUN_GROW && gen_count == DEPTH) ||
                        (run == RUN_SHRINK && gen_count == 0))
                        extra--;
                end
            end
        end
        n_total = pending_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_sent >= n_total / 3);
        tx_idle_pct = 53;
        rx_idle_pct = 14;
        wait (n_sent >= (2 * n_total) / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        wait (n_sent == n_total);
        wait (n_received >= n_sent);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && owed_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("ERROR: timeout with %0d requests sent, %0d responses", n_sent, n_received);
        $display("Test completed with failures");
        $finish;
    end

endmodule
